// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

    localparam int MAX_PATTERN_BYTES_DEF     = 16;
    localparam int MAX_REPLACEMENT_BYTES_DEF = 16;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 5;
    localparam int REG_W  = 64;
    localparam int IDX_W  = 3;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_PAT_LO  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PAT_HI  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PAT_LEN = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REP_LO  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_REP_HI  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_REP_LEN = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_present;
        logic              out_last;
    } t_out_item;

    // window cell control
    typedef struct packed {
        logic wr;
        logic shift;
    } t_win_ctl;

    // emit cell control
    typedef struct packed {
        logic load;
        logic shift;
    } t_out_ctl;

endpackage

// File: rtl/sfr_win_cell.sv
`timescale 1ns / 1ps
module sfr_win_cell
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  t_win_ctl          i_ctl,
    input  logic [BYTE_W-1:0] i_din,
    input  logic [BYTE_W-1:0] i_nbr,
    input  logic [BYTE_W-1:0] i_pat,
    input  logic              i_care,
    output logic [BYTE_W-1:0] o_cur,
    output logic              o_match
);

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // window content as seen after the incoming byte is placed
    assign o_cur   = i_ctl.wr ? i_din : r_byte;
    assign o_match = !i_care || (o_cur == i_pat);

    always_comb begin
        if (i_ctl.shift) begin
            n_byte = i_nbr;
        end else begin
            n_byte = o_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// File: rtl/sfr_out_cell.sv
`timescale 1ns / 1ps
module sfr_out_cell
    import sfr_pkg::*;
(
    input  logic      i_clk,
    input  t_out_ctl  i_ctl,
    input  t_out_item i_load,
    input  t_out_item i_nbr,
    output t_out_item o_item
);

    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        if (i_ctl.load) begin
            n_item = i_load;
        end else if (i_ctl.shift) begin
            n_item = i_nbr;
        end else begin
            n_item = r_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_item = r_item;

endmodule

// File: rtl/stream_find_and_replace_unit.sv
// the first result of a byte is offered in the cycle after its transfer
// throughput: one byte per cycle while each byte yields at most one result and the
//   output does not stall; a byte that yields n results (n up to 16) holds the input
//   until the emit row, draining one result per cycle unless stalled, has one left
// reset: synchronous active low; window empty, emit row empty, registers to defaults
`timescale 1ns / 1ps
module stream_find_and_replace_unit
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES     = MAX_PATTERN_BYTES_DEF,
    parameter int MAX_REPLACEMENT_BYTES = MAX_REPLACEMENT_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    localparam int WinDepth = MAX_PATTERN_BYTES;
    localparam int OutDepth = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
                              MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;
    localparam int FillW    = $clog2(WinDepth + 1);
    localparam int CntW     = $clog2(OutDepth + 1);

    // configuration
    logic [2*REG_W-1:0] r_pat;
    logic [2*REG_W-1:0] r_rep;
    logic [LEN_W-1:0]   r_plen;
    logic [LEN_W-1:0]   r_rlen;

    logic [FillW-1:0]   r_fill;
    logic [FillW-1:0]   n_fill;
    logic [CntW-1:0]    r_cnt;
    logic [CntW-1:0]    n_cnt;

    logic [LEN_W-1:0]   plen;
    logic [LEN_W-1:0]   rlen;
    logic [LEN_W-1:0]   fill_ext;
    logic               full;
    logic               hit;
    logic               last;
    logic [LEN_W-1:0]   n_res;
    logic [LEN_W-1:0]   last_pos;
    logic               marker;
    logic               in_xfer;
    logic               out_xfer;

    logic [BYTE_W-1:0]  win_cur [WinDepth];
    logic [WinDepth-1:0] win_match;
    t_out_item          out_item [OutDepth];
    t_out_item          out_load [OutDepth];
    t_out_ctl           out_ctl;

    always_comb begin
        if (r_plen == '0) begin
            plen = LEN_W'(1);
        end else if (r_plen > LEN_W'(MAX_PATTERN_BYTES)) begin
            plen = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            plen = r_plen;
        end
        if (r_rlen > LEN_W'(MAX_REPLACEMENT_BYTES)) begin
            rlen = LEN_W'(MAX_REPLACEMENT_BYTES);
        end else begin
            rlen = r_rlen;
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign out_xfer    = o_out_valid && !i_out_stall;
    // take a byte once the emit row is empty or its only result leaves now
    assign o_in_stall  = !((r_cnt == '0) || ((r_cnt == CntW'(1)) && out_xfer));
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out       = out_item[0];

    assign fill_ext = LEN_W'(r_fill);
    assign full     = (LEN_W'(fill_ext + 1'b1) == plen);
    assign hit      = full && (&win_match);
    assign last     = i_in.end_of_text;

    always_comb begin
        if (hit) begin
            n_res = rlen;
        end else if (full) begin
            n_res = last ? plen : LEN_W'(1);
        end else begin
            n_res = last ? LEN_W'(fill_ext + 1'b1) : '0;
        end
        marker   = last && (n_res == '0);
        last_pos = (n_res == '0) ? '0 : LEN_W'(n_res - 1'b1);
    end

    // window: a row of byte cells shifting toward cell 0
    for (genvar k = 0; k < WinDepth; k++) begin : g_win
        t_win_ctl          ctl;
        logic [BYTE_W-1:0] nbr;

        assign ctl.wr    = in_xfer && (r_fill == FillW'(k));
        assign ctl.shift = in_xfer && full && !hit;

        if (k == WinDepth - 1) begin : g_top
            assign nbr = win_cur[k];
        end else begin : g_mid
            assign nbr = win_cur[k+1];
        end

        sfr_win_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_din   (i_in.text_byte),
            .i_nbr   (nbr),
            .i_pat   (r_pat[BYTE_W*k +: BYTE_W]),
            .i_care  (LEN_W'(k) < plen),
            .o_cur   (win_cur[k]),
            .o_match (win_match[k])
        );
    end

    assign out_ctl.load  = in_xfer;
    assign out_ctl.shift = out_xfer;

    // emit row: results of one byte loaded at once, drained from cell 0
    for (genvar j = 0; j < OutDepth; j++) begin : g_out
        logic [BYTE_W-1:0] src;
        t_out_item         nbr;

        if (j < WinDepth) begin : g_win_src
            assign src = hit ? r_rep[BYTE_W*j +: BYTE_W] : win_cur[j];
        end else begin : g_rep_src
            assign src = hit ? r_rep[BYTE_W*j +: BYTE_W] : '0;
        end

        assign out_load[j].out_byte     = marker ? '0 : src;
        assign out_load[j].byte_present = (LEN_W'(j) < n_res);
        assign out_load[j].out_last     = last && (LEN_W'(j) == last_pos);

        if (j == OutDepth - 1) begin : g_top
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = out_item[j+1];
        end

        sfr_out_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (out_ctl),
            .i_load (out_load[j]),
            .i_nbr  (nbr),
            .o_item (out_item[j])
        );
    end

    always_comb begin
        n_cnt = r_cnt;
        if (in_xfer) begin
            n_cnt = marker ? CntW'(1) : CntW'(n_res);
        end else if (out_xfer) begin
            n_cnt = CntW'(r_cnt - 1'b1);
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (in_xfer) begin
            if (hit || last) begin
                n_fill = '0;
            end else if (!full) begin
                n_fill = FillW'(r_fill + 1'b1);
            end
        end
        if (i_cfg_we && (i_cfg_idx == CFG_PAT_LEN)) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            r_fill <= n_fill;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_rep  <= '0;
            r_plen <= LEN_W'(1);
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAT_LO:  r_pat[REG_W-1:0]       <= i_cfg_data;
                CFG_PAT_HI:  r_pat[2*REG_W-1:REG_W] <= i_cfg_data;
                CFG_PAT_LEN: r_plen                 <= i_cfg_data[LEN_W-1:0];
                CFG_REP_LO:  r_rep[REG_W-1:0]       <= i_cfg_data;
                CFG_REP_HI:  r_rep[2*REG_W-1:REG_W] <= i_cfg_data;
                CFG_REP_LEN: r_rlen                 <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
